FILE: sv/aljs_pkg.sv
// Shared types and register codes for the angle-limit joint solver.
package aljs_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned INDEX_W = 3;

  typedef enum logic [1:0] {
    MODE_INACTIVE = 2'd0,
    MODE_LOWER    = 2'd1,
    MODE_UPPER    = 2'd2,
    MODE_EQUAL    = 2'd3
  } mode_t;

  localparam logic [INDEX_W-1:0] REG_ANGLE_OFFSET = 3'd0;
  localparam logic [INDEX_W-1:0] REG_MIN_ANGLE    = 3'd1;
  localparam logic [INDEX_W-1:0] REG_MAX_ANGLE    = 3'd2;
  localparam logic [INDEX_W-1:0] REG_BIAS_FACTOR  = 3'd3;
  localparam logic [INDEX_W-1:0] REG_SOFTNESS     = 3'd4;
  localparam logic [INDEX_W-1:0] REG_SLOP_BAND    = 3'd5;

  localparam logic [30:0] SLOP_BAND_RESET = 31'd2287;

  localparam logic KIND_PREPARE = 1'b0;
  localparam logic KIND_SOLVE   = 1'b1;

endpackage

FILE: sv/angle_limit_joint_solver_unit.sv
// Angle-limit joint solver: sequenced datapath around one multiplier and one divider.
//
// Usage. Input words arrive on item_valid/item_ready. A prepare word (kind 0)
// classifies the relative angle against the limits, sets the bias, recomputes
// the effective mass and optionally warm starts the velocities. A solve word
// (kind 1) applies one velocity iteration. Every input word gives exactly one
// result word on result_valid/result_ready. The user must write registers
// through cfg_write/cfg_index/cfg_data while idle; the block does not enforce it.
//
// The time of a prepare word is set by the restoring divider, with one quotient
// bit per cycle over 2*FRAC_BITS+1 bits, and is longer with warm start on an
// active limit; with a zero mass denominator the divider is skipped. A solve
// word on an active limit is set by four products through the shared
// multiplier, and is shorter when the limit is inactive. One word is in
// flight at a time; item_ready rises as the result word is loaded.
//
// Reset clears registers to their defaults, the joint state to zero and the
// mode to inactive. A stalled receiver only holds the finished result word;
// the next input word is accepted and worked on, and waits in its last step
// until the output register frees up.
module angle_limit_joint_solver_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_write,
  input  logic [aljs_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [aljs_pkg::DATA_W-1:0]   cfg_data,
  // input words
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic                          kind,
  input  logic signed [31:0]            angle_a,
  input  logic signed [31:0]            angle_b,
  input  logic signed [31:0]            vel_a,
  input  logic signed [31:0]            vel_b,
  input  logic [30:0]                   inv_inertia_a,
  input  logic [30:0]                   inv_inertia_b,
  input  logic [30:0]                   inv_step,
  input  logic                          warm_start,
  // result words
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic signed [31:0]            new_vel_a,
  output logic signed [31:0]            new_vel_b,
  output logic [1:0]                    limit_mode,
  output logic signed [31:0]            impulse_total
);

  // Quotient bits of 2^(2*FRAC_BITS) / k, and the counter that walks them.
  localparam int unsigned DIVW  = 2 * FRAC_BITS + 1;
  localparam int unsigned CNT_W = $clog2(DIVW);
  localparam logic [CNT_W-1:0] DIV_TOP = CNT_W'(2 * FRAC_BITS);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_CLASS,
    ST_MUL_ERR,
    ST_MUL_STEP,
    ST_BIAS,
    ST_WARM_A,
    ST_WARM_B,
    ST_WARM_END,
    ST_DIV,
    ST_MASS,
    ST_SOLVE,
    ST_RHS,
    ST_LAMBDA,
    ST_ACCUM,
    ST_DELTA,
    ST_APPLY_A,
    ST_APPLY_B,
    ST_APPLY_END,
    ST_OUT
  } state_t;

  // Saturate a 34-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat34(input logic signed [33:0] x);
    logic hi_same;
    hi_same = (&x[33:31]) || !(|x[33:31]);
    if (hi_same) begin
      return x[31:0];
    end
    return x[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  function automatic logic signed [33:0] sx34(input logic signed [31:0] x);
    return {{2{x[31]}}, x};
  endfunction

  // Fixed-point rescale of a full product: floor shift, then saturate.
  function automatic logic signed [31:0] fx_scale(input logic signed [63:0] p);
    logic signed [63:0] s;
    logic hi_same;
    s = p >>> FRAC_BITS;
    hi_same = (&s[63:31]) || !(|s[63:31]);
    if (hi_same) begin
      return s[31:0];
    end
    return s[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  function automatic logic signed [31:0] clamp_imp(input logic signed [31:0] v,
                                                   input aljs_pkg::mode_t m);
    unique case (m)
      aljs_pkg::MODE_LOWER:    return (v > 0) ? v : 32'sd0;
      aljs_pkg::MODE_UPPER:    return (v < 0) ? v : 32'sd0;
      aljs_pkg::MODE_INACTIVE: return 32'sd0;
      aljs_pkg::MODE_EQUAL:    return v;
      default:                 return v;
    endcase
  endfunction

  // Configuration registers.
  logic signed [31:0] angle_offset;
  logic signed [31:0] min_angle;
  logic signed [31:0] max_angle;
  logic signed [31:0] bias_factor;
  logic signed [31:0] softness;
  logic [30:0]        slop_band;

  // Joint state.
  logic signed [31:0] accum_impulse;
  logic signed [31:0] bias_term;
  logic signed [31:0] eff_mass;
  aljs_pkg::mode_t    mode_reg;

  // Sequencer and working registers.
  state_t             state;
  logic               warm_reg;
  logic signed [31:0] ang_a_reg;
  logic signed [31:0] ang_b_reg;
  logic signed [31:0] va_reg;
  logic signed [31:0] vb_reg;
  logic [30:0]        inv_a_reg;
  logic [30:0]        inv_b_reg;
  logic [30:0]        inv_step_reg;
  logic signed [31:0] cur_reg;
  logic signed [32:0] lo_bound;
  logic signed [32:0] hi_bound;
  logic               limits_equal;
  logic signed [31:0] work_val;
  logic [32:0]        k_mag;
  logic               k_neg;
  logic               k_zero;
  logic [32:0]        rem;
  logic [DIVW-1:0]    quo;
  logic [CNT_W-1:0]   div_cnt;

  // Shared multiplier.
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod;
  logic signed [31:0] prod_fx;

  // Combinational helpers.
  logic signed [33:0] k_sum;
  logic signed [31:0] hi_angle;
  logic signed [33:0] cur34;
  logic               below_lo;
  logic               above_hi;
  logic [33:0]        rem_shift;
  logic               div_fit;
  logic [63:0]        quo_wide;
  logic signed [31:0] mass_val;
  logic signed [31:0] rhs_sat;
  logic signed [31:0] next_imp;

  assign item_ready = (state == ST_IDLE);
  assign prod_fx    = fx_scale(prod);

  always_comb begin
    unique case (state)
      ST_MUL_ERR:  begin mul_a = work_val;      mul_b = bias_factor;                 end
      ST_MUL_STEP: begin mul_a = prod_fx;       mul_b = $signed({1'b0, inv_step_reg}); end
      ST_WARM_A:   begin mul_a = accum_impulse; mul_b = $signed({1'b0, inv_a_reg});  end
      ST_WARM_B:   begin mul_a = accum_impulse; mul_b = $signed({1'b0, inv_b_reg});  end
      ST_SOLVE:    begin mul_a = accum_impulse; mul_b = softness;                    end
      ST_LAMBDA:   begin mul_a = eff_mass;      mul_b = work_val;                    end
      ST_APPLY_A:  begin mul_a = work_val;      mul_b = $signed({1'b0, inv_a_reg});  end
      ST_APPLY_B:  begin mul_a = work_val;      mul_b = $signed({1'b0, inv_b_reg});  end
      default:     begin mul_a = '0;            mul_b = '0;                          end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_comb begin
    k_sum    = $signed({3'b000, inv_a_reg}) + $signed({3'b000, inv_b_reg}) + sx34(softness);
    // An upper limit below the lower one is taken equal to the lower one.
    hi_angle = (max_angle > min_angle) ? max_angle : min_angle;
    cur34    = sx34(cur_reg);
    below_lo = cur34 < $signed({lo_bound[32], lo_bound});
    above_hi = cur34 > $signed({hi_bound[32], hi_bound});
    // Restoring division step: the dividend is a single one at its top bit.
    rem_shift = {rem, (div_cnt == DIV_TOP)};
    div_fit   = rem_shift >= {1'b0, k_mag};
    quo_wide  = 64'(quo);
    if (k_neg) begin
      mass_val = (quo_wide > 64'h8000_0000) ? 32'sh8000_0000 : -$signed(quo_wide[31:0]);
    end else begin
      mass_val = (quo_wide > 64'h7fff_ffff) ? 32'sh7fff_ffff : $signed(quo_wide[31:0]);
    end
    rhs_sat  = sat34(sx34(work_val) + sx34(bias_term) + sx34(prod_fx));
    next_imp = clamp_imp(sat34(sx34(accum_impulse) + sx34(prod_fx)), mode_reg);
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_offset <= '0;
      min_angle    <= '0;
      max_angle    <= '0;
      bias_factor  <= '0;
      softness     <= '0;
      slop_band    <= aljs_pkg::SLOP_BAND_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        aljs_pkg::REG_ANGLE_OFFSET: angle_offset <= $signed(cfg_data);
        aljs_pkg::REG_MIN_ANGLE:    min_angle    <= $signed(cfg_data);
        aljs_pkg::REG_MAX_ANGLE:    max_angle    <= $signed(cfg_data);
        aljs_pkg::REG_BIAS_FACTOR:  bias_factor  <= $signed(cfg_data);
        aljs_pkg::REG_SOFTNESS:     softness     <= $signed(cfg_data);
        aljs_pkg::REG_SLOP_BAND:    slop_band    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Sequencer, joint state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      result_valid  <= 1'b0;
      accum_impulse <= '0;
      bias_term     <= '0;
      eff_mass      <= '0;
      mode_reg      <= aljs_pkg::MODE_INACTIVE;
    end else begin
      // The output register fills from the last step and empties when taken.
      if ((state == ST_OUT) && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            warm_reg     <= warm_start;
            ang_a_reg    <= angle_a;
            ang_b_reg    <= angle_b;
            va_reg       <= vel_a;
            vb_reg       <= vel_b;
            inv_a_reg    <= inv_inertia_a;
            inv_b_reg    <= inv_inertia_b;
            inv_step_reg <= inv_step;
            state        <= (kind == aljs_pkg::KIND_SOLVE) ? ST_SOLVE : ST_ANGLE;
          end
        end

        // Prepare: relative angle, limit bounds and mass denominator.
        ST_ANGLE: begin
          cur_reg      <= sat34(sx34(ang_b_reg) - sx34(ang_a_reg) - sx34(angle_offset));
          limits_equal <= (max_angle <= min_angle);
          lo_bound     <= {min_angle[31], min_angle} - $signed({2'b00, slop_band});
          hi_bound     <= {hi_angle[31], hi_angle} + $signed({2'b00, slop_band});
          k_neg        <= k_sum[33];
          k_zero       <= (k_sum == '0);
          k_mag        <= k_sum[33] ? 33'(-k_sum) : k_sum[32:0];
          rem          <= '0;
          div_cnt      <= DIV_TOP;
          state        <= ST_CLASS;
        end

        ST_CLASS: begin
          priority if (limits_equal) begin
            mode_reg <= aljs_pkg::MODE_EQUAL;
            work_val <= sat34(cur34 - sx34(min_angle));
          end else if (below_lo) begin
            mode_reg <= aljs_pkg::MODE_LOWER;
            work_val <= sat34(cur34 - {lo_bound[32], lo_bound});
          end else if (above_hi) begin
            mode_reg <= aljs_pkg::MODE_UPPER;
            work_val <= sat34(cur34 - {hi_bound[32], hi_bound});
          end else begin
            mode_reg <= aljs_pkg::MODE_INACTIVE;
            work_val <= '0;
          end
          state <= ST_MUL_ERR;
        end

        ST_MUL_ERR:  state <= ST_MUL_STEP;
        ST_MUL_STEP: state <= ST_BIAS;

        ST_BIAS: begin
          bias_term     <= (mode_reg == aljs_pkg::MODE_INACTIVE) ? 32'sd0 : prod_fx;
          accum_impulse <= clamp_imp(accum_impulse, mode_reg);
          if (warm_reg && (mode_reg != aljs_pkg::MODE_INACTIVE)) begin
            state <= ST_WARM_A;
          end else begin
            state <= k_zero ? ST_OUT : ST_DIV;
          end
        end

        ST_WARM_A: state <= ST_WARM_B;
        ST_WARM_B: begin
          va_reg <= sat34(sx34(va_reg) - sx34(prod_fx));
          state  <= ST_WARM_END;
        end
        ST_WARM_END: begin
          vb_reg <= sat34(sx34(vb_reg) + sx34(prod_fx));
          state  <= k_zero ? ST_OUT : ST_DIV;
        end

        ST_DIV: begin
          if (div_fit) begin
            rem <= 33'(rem_shift - {1'b0, k_mag});
          end else begin
            rem <= rem_shift[32:0];
          end
          quo <= {quo[DIVW-2:0], div_fit};
          if (div_cnt == '0) begin
            state <= ST_MASS;
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end

        ST_MASS: begin
          eff_mass <= mass_val;
          state    <= ST_OUT;
        end

        // Solve: one sequential-impulse velocity iteration.
        ST_SOLVE: begin
          work_val <= sat34(sx34(vb_reg) - sx34(va_reg));
          state    <= (mode_reg == aljs_pkg::MODE_INACTIVE) ? ST_OUT : ST_RHS;
        end

        ST_RHS: begin
          work_val <= (rhs_sat == 32'sh8000_0000) ? 32'sh7fff_ffff : -rhs_sat;
          state    <= ST_LAMBDA;
        end

        ST_LAMBDA: state <= ST_ACCUM;

        ST_ACCUM: begin
          work_val <= next_imp;
          state    <= ST_DELTA;
        end

        ST_DELTA: begin
          work_val      <= sat34(sx34(work_val) - sx34(accum_impulse));
          accum_impulse <= work_val;
          state         <= ST_APPLY_A;
        end

        ST_APPLY_A: state <= ST_APPLY_B;
        ST_APPLY_B: begin
          va_reg <= sat34(sx34(va_reg) - sx34(prod_fx));
          state  <= ST_APPLY_END;
        end
        ST_APPLY_END: begin
          vb_reg <= sat34(sx34(vb_reg) + sx34(prod_fx));
          state  <= ST_OUT;
        end

        // Hold the finished word until the output register is free.
        ST_OUT: begin
          if (!result_valid || result_ready) begin
            new_vel_a     <= va_reg;
            new_vel_b     <= vb_reg;
            limit_mode    <= mode_reg;
            impulse_total <= accum_impulse;
            state         <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
